// ===== hw/rtl/pwlte_pkg.sv =====
// ----------------------------------------------------------------------------
// pwlte_pkg: shared types and constants for the piecewise linear evaluator.
// Holds the request and result structs and the status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package pwlte_pkg;

  localparam int unsigned MaxVerticesDef = 32;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncEval   = 1'b1;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusSat  = 2'd2;

  typedef struct packed {
    logic               func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/piecewise_linear_table_eval.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_eval: sorted vertex table with linear evaluation.
//
//  channel | ports                      | handshake
//  input   | start, busy, in_req        | taken when start and not busy
//  result  | out_valid, out_res         | one-cycle strobe, no back-pressure
//
// An insert does one memory read and write per moved entry. An evaluate runs
// a linear search through the table memory, a registered 32x33 multiply and
// a 64-step divider that ends with its done strobe.
// Reset clears the vertex count and the sequencer; the memories need none.
// The receiver cannot stall; busy stays high until the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module piecewise_linear_table_eval #(
  parameter int unsigned MAX_VERTICES = pwlte_pkg::MaxVerticesDef
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  pwlte_pkg::req_t   in_req,
  output logic              busy,
  output logic              out_valid,
  output pwlte_pkg::res_t   out_res
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_IRD   = 10'b0000000010,
    S_ISHF  = 10'b0000000100,
    S_SRD   = 10'b0000001000,
    S_SCHK  = 10'b0000010000,
    S_PRD   = 10'b0000100000,
    S_PCHK  = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic signed [31:0] qx_r, qy_r;

  // Vertex memory, x and y packed side by side.
  logic [63:0] mem [MAX_VERTICES];
  logic [63:0] rd_r;
  logic        we;
  logic [AW-1:0] wa, ra;
  logic [63:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  logic signed [31:0] rx, ry;
  assign rx = rd_r[63:32];
  assign ry = rd_r[31:0];

  // Saved near vertex (b).
  logic signed [31:0] bx_r, by_r;
  logic signed [32:0] a_r, dy_r, dx_r;
  logic        neg_r;
  logic [63:0] prod_r;
  logic        div_go;
  logic        div_done;
  logic [63:0] quo;

  pwlte_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go),
    .dividend(prod_r), .divisor(dx_r[32] ? -dx_r : dx_r),
    .done(div_done), .quotient(quo)
  );

  // Final sign apply and saturation.
  logic signed [35:0] res_w;
  logic        big;
  assign big   = quo > 64'h4_0000_0000;
  assign res_w = {{4{by_r[31]}}, by_r} -
                 (neg_r ? -$signed({1'b0, quo[34:0]}) : $signed({1'b0, quo[34:0]}));

  logic [32:0] amag, dymag;
  assign amag  = a_r[32] ? -a_r : a_r;
  assign dymag = dy_r[32] ? -dy_r : dy_r;

  always_comb begin
    we = 1'b0;
    wa = idx_r[AW-1:0];
    wd = {qx_r, qy_r};
    ra = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: ra = '0;
      S_ISHF: begin
        we = 1'b1;
        if (idx_r != '0 && rx > qx_r) wd = rd_r;
        ra = idx_r[AW-1:0] - AW'(2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && !busy) begin
            busy <= 1'b1;
            qx_r <= in_req.point_x;
            qy_r <= in_req.point_y;
            out_res.value <= '0;
            out_res.status <= pwlte_pkg::StatusOk;
            if (in_req.func == pwlte_pkg::FuncInsert) begin
              if (cnt_r >= CW'(MAX_VERTICES)) begin
                out_res.status <= pwlte_pkg::StatusFull;
                state_r <= S_FIN;
              end else if (cnt_r == '0) begin
                idx_r <= '0;
                state_r <= S_ISHF;
              end else begin
                idx_r <= cnt_r - CW'(1);
                state_r <= S_IRD;
              end
            end else begin
              idx_r <= '0;
              if (cnt_r == '0) state_r <= S_FIN;
              else state_r <= S_SRD;
            end
          end
        end
        // Insert: read entry idx, then walk down writing entry idx+1.
        S_IRD: begin
          idx_r <= idx_r + CW'(1);
          state_r <= S_ISHF;
        end
        S_ISHF: begin
          if (idx_r == '0 || !(rx > qx_r)) begin
            cnt_r <= cnt_r + CW'(1);
            state_r <= S_FIN;
          end else begin
            idx_r <= idx_r - CW'(1);
          end
        end
        // Search: lower bound of query x.
        S_SRD: state_r <= S_SCHK;
        S_SCHK: begin
          if (cnt_r == CW'(1)) begin
            out_res.value <= ry;
            state_r <= S_FIN;
          end else if (rx == qx_r) begin
            out_res.value <= ry;
            state_r <= S_FIN;
          end else if (rx > qx_r || idx_r == cnt_r - CW'(1)) begin
            // Near vertex is the lower bound, or the last on overrun.
            bx_r <= rx; by_r <= ry;
            if (rx > qx_r && idx_r == '0) idx_r <= CW'(1);
            else idx_r <= idx_r - CW'(1);
            state_r <= S_PRD;
          end else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_SRD;
          end
        end
        S_PRD: state_r <= S_PCHK;
        S_PCHK: begin
          dx_r <= 33'(rx) - 33'(bx_r);
          dy_r <= 33'(ry) - 33'(by_r);
          a_r  <= 33'(bx_r) - 33'(qx_r);
          if (rx == bx_r) begin
            out_res.value <= by_r;
            state_r <= S_FIN;
          end else state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= {32'd0, amag[31:0]} * {31'd0, dymag};
          neg_r  <= a_r[32] ^ dy_r[32] ^ dx_r[32];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (big) begin
              out_res.value <= neg_r ? 32'sh7FFF_FFFF : 32'sh8000_0000;
              out_res.status <= pwlte_pkg::StatusSat;
            end else if (res_w > 36'sh0_7FFF_FFFF) begin
              out_res.value <= 32'sh7FFF_FFFF;
              out_res.status <= pwlte_pkg::StatusSat;
            end else if (res_w < -36'sh0_8000_0000) begin
              out_res.value <= 32'sh8000_0000;
              out_res.status <= pwlte_pkg::StatusSat;
            end else out_res.value <= res_w[31:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid <= 1'b1;
          busy <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Divider launch, registered on the same edge as the product.
  logic go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) go_r <= 1'b0;
    else go_r <= (state_r == S_MUL);
  end
  assign div_go = go_r;

endmodule
`default_nettype wire

// ===== hw/rtl/pwlte_div.sv =====
// ----------------------------------------------------------------------------
// pwlte_div: unsigned restoring divider.
// Divides a 64-bit magnitude by a 33-bit magnitude, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pwlte_div (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [63:0] dividend,
  input  wire  [32:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] quo_r;
  logic [33:0] rem_r;
  logic [32:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        run_r;
  logic [34:0] trial;

  // One shift-subtract step per cycle.
  assign trial = {rem_r, quo_r[63]} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 7'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= 34'd0;
      dvs_r <= divisor;
    end else if (run_r) begin
      if (!trial[34]) begin
        rem_r <= trial[33:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[32:0], quo_r[63]};
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/pwlte_checker.sv =====
// ----------------------------------------------------------------------------
// pwlte_checker: port-level checks on the evaluator handshake.
// Bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module pwlte_checker (
  input wire             clk,
  input wire             rst_n,
  input wire             start,
  input wire             busy,
  input wire             out_valid,
  input pwlte_pkg::res_t out_res
);

  // An accepted request makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");

  // A result ends the busy period.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy after result");

  // Results are single-cycle strobes.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");

  // Status is always one of the defined codes.
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.status == pwlte_pkg::StatusOk ||
                   out_res.status == pwlte_pkg::StatusFull ||
                   out_res.status == pwlte_pkg::StatusSat)) else $error("bad status");

endmodule

bind piecewise_linear_table_eval pwlte_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_res(out_res)
);
`default_nettype wire
